// File: rtl/core/wpc_pkg.sv
// Shared types and constants for the windowed peak counter.
// No dependencies; imported by every module of the block.
package wpc_pkg;

    // Sizing of the sample window
    localparam int MAX_HALF_WINDOW = 7;
    localparam int SAMPLE_BITS     = 10;
    localparam int WIN_DEPTH       = 2 * MAX_HALF_WINDOW + 1;
    localparam int IDX_BITS        = $clog2(WIN_DEPTH);
    localparam int FILL_BITS       = $clog2(WIN_DEPTH + 1);

    // Register fields and count
    localparam int HALF_BITS   = 3;
    localparam int THR_BITS    = 10;
    localparam int COUNT_BITS  = 16;
    localparam int CMP_BITS    = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;

    localparam logic [HALF_BITS-1:0] HALF_WINDOW_RESET = 3'd2;
    localparam logic [THR_BITS-1:0]  THRESHOLD_RESET   = 10'd520;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX        = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WINDOW    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PEAK_THRESHOLD = 2'd1;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    // Input word
    typedef struct packed {
        sample_t sample;
        logic    record_start;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic                  center_valid;
        logic                  is_peak;
        logic [COUNT_BITS-1:0] peak_count;
    } result_t;

    // Per-cell comparison against the centre sample
    typedef struct packed {
        logic gt;
        logic ge;
    } cmp_t;

endpackage

// File: rtl/core/wpc_cell.sv
// One cell of the sample shift line: holds one sample and compares its
// incoming value with the centre sample. Depends on wpc_pkg.
module wpc_cell
    import wpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    shift_en,
    input  sample_t shift_in,
    input  sample_t center,
    output sample_t value,
    output cmp_t    cmp
);

    sample_t value_reg;
    sample_t value_next;

    // Take the neighbour's sample on every accepted word
    always_comb
    begin
        value_next = shift_en ? shift_in : value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    // Compare the sample this cell is about to hold with the centre
    always_comb
    begin
        cmp.gt = (shift_in > center);
        cmp.ge = (shift_in >= center);
    end

    assign value = value_reg;

endmodule

// File: rtl/core/wpc_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on wpc_pkg.
module wpc_out_buf
    import wpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_word,
    output logic    full,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_word
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_word_reg, out_word_next;
    result_t skid_word_reg, skid_word_next;
    logic    pop;

    assign pop = out_valid_reg && !result_stall;

    // Drain the skid entry first, otherwise land the new word
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_word_next  = push_word;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_word_next  = push_word;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign full         = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule

// File: rtl/core/windowed_peak_counter_core.sv
// Windowed peak counter: each accepted sample word yields one registered result
// word, and a new sample word is taken every cycle unless the result buffer is full.
// The rate is set by a combinational compare of the centre sample against all window
// cells at once; a two-entry result buffer keeps input flowing while a result waits.
// Depends on wpc_pkg, wpc_cell and wpc_out_buf.
module windowed_peak_counter_core
    import wpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  in_word_t                 sample_word,
    output logic                     result_valid,
    input  logic                     result_stall,
    output result_t                  result_word,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic [HALF_BITS-1:0]  half_reg, half_next;
    logic [THR_BITS-1:0]   thr_reg, thr_next;
    logic [FILL_BITS-1:0]  fill_reg, fill_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic                  accept;
    logic                  buf_full;
    logic [HALF_BITS-1:0]  half_eff;
    logic [IDX_BITS-1:0]   center_idx;
    sample_t               center;
    sample_t               win_in [WIN_DEPTH];
    sample_t               win_q  [WIN_DEPTH];
    cmp_t                  cmp    [WIN_DEPTH];
    logic                  peak_raw;
    logic                  center_ok;
    logic [FILL_BITS-1:0]  fill_base;
    logic [FILL_BITS-1:0]  fill_need;
    logic [COUNT_BITS-1:0] count_base;
    result_t               res;

    assign cfg_ready    = 1'b1;
    assign sample_stall = buf_full;
    assign accept       = sample_valid && !buf_full;

    // Register writes
    always_comb
    begin
        half_next = half_reg;
        thr_next  = thr_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HALF_WINDOW:    half_next = cfg_data[HALF_BITS-1:0];
                REG_PEAK_THRESHOLD: thr_next  = cfg_data[THR_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Clamp the half window to the built depth
    assign half_eff = (32'(half_reg) > MAX_HALF_WINDOW) ?
                      HALF_BITS'(MAX_HALF_WINDOW) : half_reg;
    assign center_idx = IDX_BITS'(half_eff);

    // Shift line of sample cells, newest at index 0
    assign win_in[0] = sample_word.sample;
    for (genvar g = 1; g < WIN_DEPTH; g++)
    begin : g_link
        assign win_in[g] = win_q[g-1];
    end

    assign center = win_in[center_idx];

    for (genvar g = 0; g < WIN_DEPTH; g++)
    begin : g_cell
        wpc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (accept),
            .shift_in (win_in[g]),
            .center   (center),
            .value    (win_q[g]),
            .cmp      (cmp[g])
        );
    end

    // Peak: centre >= threshold, > older and >= newer samples; always with half 0
    always_comb
    begin
        int hi;
        hi       = int'(half_eff);
        peak_raw = (CMP_BITS'(center) >= CMP_BITS'(thr_reg));
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            if ((i < hi) && cmp[i].gt)
            begin
                peak_raw = 1'b0;
            end
            if ((i > hi) && (i <= 2 * hi) && cmp[i].ge)
            begin
                peak_raw = 1'b0;
            end
        end
        if (half_eff == '0)
        begin
            peak_raw = 1'b1;
        end
    end

    // Advance fill level and peak count
    always_comb
    begin
        fill_base  = sample_word.record_start ? '0 : fill_reg;
        count_base = sample_word.record_start ? '0 : count_reg;
        fill_next  = (fill_base < FILL_BITS'(WIN_DEPTH)) ? fill_base + 1'b1 : fill_base;
        fill_need  = FILL_BITS'((int'(half_eff) << 1) + 1);
        center_ok  = (fill_next >= fill_need);
        count_next = count_base;
        if (center_ok && peak_raw && (count_base != COUNT_MAX))
        begin
            count_next = count_base + 1'b1;
        end
        res.center_valid = center_ok;
        res.is_peak      = center_ok && peak_raw;
        res.peak_count   = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg  <= HALF_WINDOW_RESET;
            thr_reg   <= THRESHOLD_RESET;
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            half_reg <= half_next;
            thr_reg  <= thr_next;
            if (accept)
            begin
                fill_reg  <= fill_next;
                count_reg <= count_next;
            end
        end
    end

    wpc_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept),
        .push_word    (res),
        .full         (buf_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

endmodule

// File: rtl/core/wpc_checker.sv
// Port-level checks for the windowed peak counter, bound to windowed_peak_counter_core.
// Depends on wpc_pkg and windowed_peak_counter_core.
module wpc_checker
    import wpc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    sample_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result_word
);

    // Hold a stalled result word
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_word))
        else $error("stalled result word changed");

    // Flag a peak only with a full window
    a_peak_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.is_peak |-> result_word.center_valid)
        else $error("peak without full window");

    // A peak word always carries a non-zero count
    a_peak_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.is_peak |-> result_word.peak_count != '0)
        else $error("peak with zero count");

    // Stall input only while a result word waits
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid)
        else $error("input stalled with empty output");

endmodule

bind windowed_peak_counter_core wpc_checker u_wpc_checker (.*);
